>>> src/lbpc_pkg.sv
// lbpc_pkg: shared types, codes and widths for the light-driven blind controller
// no dependencies
package lbpc_pkg;

  localparam int LIGHT_BITS = 12;
  localparam int THR_BITS   = 12;
  localparam int CMP_BITS   = (LIGHT_BITS > THR_BITS) ? LIGHT_BITS : THR_BITS;
  localparam int IDX_BITS   = 8;
  localparam int IN_BITS    = 5 + LIGHT_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [THR_BITS-1:0] DAY_RESET   = THR_BITS'(2500);
  localparam logic [THR_BITS-1:0] NIGHT_RESET = THR_BITS'(1000);

  typedef enum logic [IDX_BITS-1:0] {
    REG_DAY   = IDX_BITS'(0),
    REG_NIGHT = IDX_BITS'(1)
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_START = 2'd0,
    ST_WAIT  = 2'd1,
    ST_UP    = 2'd2,
    ST_DOWN  = 2'd3
  } ctrl_state_e;

  typedef enum logic [1:0] {
    TGT_NONE   = 2'd0,
    TGT_TOP    = 2'd1,
    TGT_MIDDLE = 2'd2,
    TGT_BOTTOM = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_RAISE = 2'd1,
    DRV_LOWER = 2'd2,
    DRV_SPARE = 2'd3
  } drive_e;

  typedef struct packed {
    logic                  auto_mode;
    logic                  at_top;
    logic                  at_middle;
    logic                  at_bottom;
    logic [LIGHT_BITS-1:0] light_level;
    logic                  button_up;
    logic                  button_down;
  } item_t;

  typedef struct packed {
    drive_e      motor_drive;
    ctrl_state_e next_state;
  } result_t;

  typedef struct packed {
    logic [THR_BITS-1:0] day;
    logic [THR_BITS-1:0] night;
  } thresholds_t;

endpackage

>>> src/lbpc_cfg.sv
// lbpc_cfg: day and night threshold registers behind the write channel
// depends on lbpc_pkg
module lbpc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbpc_pkg::IDX_BITS-1:0] cfg_index_i,
  input  logic [lbpc_pkg::THR_BITS-1:0] cfg_data_i,
  output lbpc_pkg::thresholds_t         thr_o
);
  import lbpc_pkg::*;

  thresholds_t thr_q, thr_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d = thr_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DAY:   thr_d.day   = cfg_data_i;
        REG_NIGHT: thr_d.night = cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.day   <= DAY_RESET;
      thr_q.night <= NIGHT_RESET;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

>>> src/lbpc_core.sv
// lbpc_core: control state machine, light classing and manual target register
// depends on lbpc_pkg
module lbpc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  lbpc_pkg::item_t       item_i,
  input  lbpc_pkg::thresholds_t thr_i,
  output lbpc_pkg::result_t     result_o
);
  import lbpc_pkg::*;

  ctrl_state_e state_q, state_d;
  target_e     target_q, target_d;
  drive_e      drive;
  logic        day, night, twi;
  logic [CMP_BITS-1:0] light_x, day_x, night_x;

  assign light_x = CMP_BITS'(item_i.light_level);
  assign day_x   = CMP_BITS'(thr_i.day);
  assign night_x = CMP_BITS'(thr_i.night);
  assign day     = light_x > day_x;
  assign night   = light_x <= night_x;
  assign twi     = (light_x > night_x) && (light_x <= day_x);

  always_comb begin
    state_d  = state_q;
    target_d = target_q;
    drive    = DRV_STOP;
    unique case (state_q)
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        state_d = ST_WAIT;
        if (item_i.auto_mode) begin
          if ((day && (item_i.at_middle || item_i.at_bottom)) ||
              (twi && item_i.at_bottom)) begin
            state_d = ST_UP;
          end else if ((night && (item_i.at_middle || item_i.at_top)) ||
                       (twi && item_i.at_top)) begin
            state_d = ST_DOWN;
          end
        end else if (item_i.button_up && item_i.at_bottom) begin
          state_d  = ST_UP;
          target_d = TGT_MIDDLE;
        end else if (item_i.button_up && item_i.at_middle) begin
          state_d  = ST_UP;
          target_d = TGT_TOP;
        end else if (item_i.button_down && item_i.at_top) begin
          state_d  = ST_DOWN;
          target_d = TGT_MIDDLE;
        end else if (item_i.button_down && item_i.at_middle) begin
          state_d  = ST_DOWN;
          target_d = TGT_BOTTOM;
        end
      end
      ST_UP: begin
        drive = DRV_RAISE;
        if (item_i.auto_mode) begin
          if ((day && item_i.at_top) || (twi && item_i.at_middle) || night) begin
            state_d = ST_WAIT;
          end
        end else if (item_i.at_top ||
                     (target_q == TGT_MIDDLE && item_i.at_middle)) begin
          // manual: the top switch always stops, a top target is covered by it
          state_d = ST_WAIT;
        end
      end
      ST_DOWN: begin
        drive = DRV_LOWER;
        if (item_i.auto_mode) begin
          if ((night && item_i.at_bottom) || (twi && item_i.at_middle) || day) begin
            state_d = ST_WAIT;
          end
        end else if (item_i.at_bottom ||
                     (target_q == TGT_MIDDLE && item_i.at_middle)) begin
          state_d = ST_WAIT;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_START;
      target_q <= TGT_NONE;
    end else if (step_i) begin
      state_q  <= state_d;
      target_q <= target_d;
    end
  end

  assign result_o.motor_drive = drive;
  assign result_o.next_state  = state_d;

endmodule

>>> src/light_driven_blind_position_control.sv
// light_driven_blind_position_control: top level with input and result registers
// depends on lbpc_pkg, lbpc_cfg and lbpc_core
//
// usage
//   each item on the slave stream is one sampled tick: switch levels, light level
//   and buttons in tdata, the auto/manual flag in tuser. each item gives exactly
//   one result item on the master stream: motor drive and the next control state.
//   thresholds are written through the cfg channel (index 0 day, index 1 night);
//   the channel is always ready and other indices are dropped. write only while idle.
// path and throughput
//   an item passes an input register and lands in the result register, from which
//   its result is offered on the master side; one item per cycle is sustained while
//   the receiver keeps tready high, set by the state and target register update done
//   as the item leaves the input register.
// reset
//   state goes to start (first tick stops the motor and moves to waiting), the
//   manual target clears and thresholds return to 2500 and 1000.
// stalls
//   when the receiver holds tready low the result holds, the input register
//   fills and tready on the slave side drops; no item is lost or repeated.
module light_driven_blind_position_control (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // at_top, at_middle, at_bottom, light_level, button_up, button_down, unused upper bits
  input  logic [lbpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // auto_mode
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // motor_drive, next_state, zero fill
  output logic [lbpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lbpc_pkg::IDX_BITS-1:0]    cfg_index_i,
  input  logic [lbpc_pkg::THR_BITS-1:0]    cfg_data_i
);
  import lbpc_pkg::*;

  localparam int LightLsb = 3;

  thresholds_t thr;
  item_t       in_d, in_q;
  logic        in_vld_q, out_vld_q;
  logic        advance, step;
  result_t     res, res_q;

  assign in_d.auto_mode   = s_axis_tuser;
  assign in_d.at_top      = s_axis_tdata[0];
  assign in_d.at_middle   = s_axis_tdata[1];
  assign in_d.at_bottom   = s_axis_tdata[2];
  assign in_d.light_level = s_axis_tdata[LightLsb +: LIGHT_BITS];
  assign in_d.button_up   = s_axis_tdata[LightLsb + LIGHT_BITS];
  assign in_d.button_down = s_axis_tdata[LightLsb + LIGHT_BITS + 1];

  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = advance && in_vld_q;
  assign s_axis_tready = !in_vld_q || advance;

  lbpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thr_o       (thr)
  );

  lbpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .thr_i    (thr),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, res_q.next_state, res_q.motor_drive};

endmodule
